[hw/rtl/kvc_pkg.sv]
// kvc_pkg: sizes, operation codes and shared structs for the key/data cache.
// Used by the channel interfaces, the entry store, the compare unit and the top level.
package kvc_pkg;

   localparam int ENTRIES     = 8;
   localparam int KEY_BITS    = 32;
   localparam int KEY_W       = 32;
   localparam int TAG_BITS    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
   localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W       = $clog2(ENTRIES + 1);
   localparam int STAMP_W     = 32;
   localparam int DATA_W      = 64;
   localparam int CAP_W       = 4;
   localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int CAP_RESET   = 3;
   localparam int STAMP_RESET = 1;

   typedef logic [1:0] mode_type;
   localparam mode_type MODE_ADD   = 2'd0;
   localparam mode_type MODE_GET   = 2'd1;
   localparam mode_type MODE_ERASE = 2'd2;
   localparam mode_type MODE_CLEAR = 2'd3;

   // write/kill request into the entry store
   typedef struct packed {
      logic                wen;
      logic [IDX_W-1:0]    widx;
      logic [TAG_BITS-1:0] key;
      logic [DATA_W-1:0]   data;
      logic [STAMP_W-1:0]  stamp;
      logic                ken;
      logic [IDX_W-1:0]    kidx;
   } wr_type;

   // one entry as read from the store
   typedef struct packed {
      logic                valid;
      logic [TAG_BITS-1:0] key;
      logic [DATA_W-1:0]   data;
      logic [STAMP_W-1:0]  stamp;
   } ent_type;

   // compare unit verdict
   typedef struct packed {
      logic hit;
      logic better;
   } cmp_type;

endpackage

[hw/rtl/kvc_if.sv]
// kvc_if: valid/ready channel interfaces for request, response and capacity write.
// Depends on kvc_pkg for field widths.
interface kvc_req_if import kvc_pkg::*; ();
   logic              valid;
   logic              ready;
   mode_type          mode;
   logic [KEY_W-1:0]  key;
   logic [DATA_W-1:0] value;
   modport source (output valid, mode, key, value, input ready);
   modport sink   (input valid, mode, key, value, output ready);
endinterface

interface kvc_rsp_if import kvc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              found;
   logic [DATA_W-1:0] data;
   logic              released;
   logic              last;
   modport source (output valid, found, data, released, last, input ready);
   modport sink   (input valid, found, data, released, last, output ready);
endinterface

interface kvc_csr_if import kvc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CAP_W-1:0] capacity;
   modport source (output valid, capacity, input ready);
   modport sink   (input valid, capacity, output ready);
endinterface

[hw/rtl/kvc_store.sv]
// kvc_store: entry array (key, data, stamp) with per-entry valid bits.
// One write/kill port, one read port. Depends on kvc_pkg.
module kvc_store import kvc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  wr_type           wr,
   input  logic [IDX_W-1:0] rd_idx,
   output ent_type          rd
);

   logic [TAG_BITS-1:0] key_ff   [ENTRIES];
   logic [DATA_W-1:0]   data_ff  [ENTRIES];
   logic [STAMP_W-1:0]  stamp_ff [ENTRIES];
   logic [ENTRIES-1:0]  valid_ff;
   logic [ENTRIES-1:0]  valid_in;

   always_comb begin
      valid_in = valid_ff;
      if (wr.ken) begin
         valid_in[wr.kidx] = 1'b0;
      end
      // a write to the killed slot wins
      if (wr.wen) begin
         valid_in[wr.widx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.wen) begin
         key_ff[wr.widx]   <= wr.key;
         data_ff[wr.widx]  <= wr.data;
         stamp_ff[wr.widx] <= wr.stamp;
      end
   end

   assign rd.valid = valid_ff[rd_idx];
   assign rd.key   = key_ff[rd_idx];
   assign rd.data  = data_ff[rd_idx];
   assign rd.stamp = stamp_ff[rd_idx];

endmodule

[hw/rtl/kvc_cmp.sv]
// kvc_cmp: shared compare unit used once per scanned entry.
// Key match against the probe, and "better candidate" by age or by key. Depends on kvc_pkg.
module kvc_cmp import kvc_pkg::*; (
   input  logic [TAG_BITS-1:0] ent_key,
   input  logic [STAMP_W-1:0]  ent_stamp,
   input  logic [TAG_BITS-1:0] best_key,
   input  logic [STAMP_W-1:0]  best_stamp,
   input  logic [TAG_BITS-1:0] probe_key,
   input  logic                key_order,
   output cmp_type             res
);

   logic key_lt;
   logic older;

   assign key_lt = ent_key < best_key;
   // equal stamps only after wrap; smaller key counts as older
   assign older  = (ent_stamp < best_stamp) || ((ent_stamp == best_stamp) && key_lt);

   assign res.hit    = ent_key == probe_key;
   assign res.better = key_order ? key_lt : older;

endmodule

[hw/rtl/fifo_replacement_kv_cache.sv]
// fifo_replacement_kv_cache: fully associative key/data cache with oldest-first eviction.
// Uses kvc_pkg, kvc_if (channels), kvc_store and kvc_cmp.
//
//   channel   dir   payload                          role
//   req_ch    in    mode, key, value                 add / get / erase / clear
//   rsp_ch    out   found, data, released, last      lookup data or words to free
//   csr_ch    in    capacity                         eviction threshold
//
// A scan reads all ENTRIES slots, one per cycle through the compare unit, and the apply
// state then acts on its result before the block returns to idle for the next word.
// A clear repeats scan and apply per released word; an empty store releases none.
// Not ready for a new item until the current one is finished; a response stalls the
// apply cycle only while the output register still holds an untaken word.
// reset is synchronous, active high; it clears the valid bits and sets capacity (3) and the stamp (1).
module fifo_replacement_kv_cache import kvc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   kvc_req_if.sink  req_ch,
   kvc_rsp_if.source rsp_ch,
   kvc_csr_if.sink  csr_ch
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_APPLY = 3'b100
   } state_type;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   state_type state_ff, state_in;

   mode_type            mode_ff, mode_in;
   logic [TAG_BITS-1:0] key_ff, key_in;
   logic [DATA_W-1:0]   value_ff, value_in;
   logic [CAP_W-1:0]    cap_ff, cap_in;
   logic [STAMP_W-1:0]  stamp_ff, stamp_in;

   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                best_vld_ff, best_vld_in;
   logic [IDX_W-1:0]    best_ff, best_in;
   logic [TAG_BITS-1:0] best_key_ff, best_key_in;
   logic [STAMP_W-1:0]  best_stamp_ff, best_stamp_in;
   logic                match_vld_ff, match_vld_in;
   logic [IDX_W-1:0]    match_ff, match_in;
   logic                free_vld_ff, free_vld_in;
   logic [IDX_W-1:0]    free_ff, free_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                found_ff, found_in;
   logic [DATA_W-1:0]   data_ff, data_in;
   logic                released_ff, released_in;
   logic                last_ff, last_in;

   wr_type              wr;
   ent_type             ent;
   cmp_type             cmp;
   logic [IDX_W-1:0]    rd_idx;
   logic [IDX_W-1:0]    add_slot;
   logic [CMP_W-1:0]    cap_ext;
   logic [CMP_W-1:0]    cap_eff;
   logic                evict;
   logic                out_free;
   logic                load;
   logic                scan_start;

   kvc_store u_store (
      .clock  (clock),
      .reset  (reset),
      .wr     (wr),
      .rd_idx (rd_idx),
      .rd     (ent)
   );

   kvc_cmp u_cmp (
      .ent_key    (ent.key),
      .ent_stamp  (ent.stamp),
      .best_key   (best_key_ff),
      .best_stamp (best_stamp_ff),
      .probe_key  (key_ff),
      .key_order  (mode_ff == MODE_CLEAR),
      .res        (cmp)
   );

   assign req_ch.ready = state_ff == ST_IDLE;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.found    = found_ff;
   assign rsp_ch.data     = data_ff;
   assign rsp_ch.released = released_ff;
   assign rsp_ch.last     = last_ff;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // effective capacity is limited to the store size
   assign cap_ext = CMP_W'(cap_ff);
   assign cap_eff = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
   assign evict   = (CMP_W'(cnt_ff) >= cap_eff) && (cnt_ff != '0);

   // add target: existing key unless it was just evicted, else the lowest free slot, or on eviction the victim if lower
   always_comb begin
      if (match_vld_ff && !(evict && match_ff == best_ff)) begin
         add_slot = match_ff;
      end else if (evict) begin
         add_slot = (free_vld_ff && free_ff < best_ff) ? free_ff : best_ff;
      end else if (free_vld_ff) begin
         add_slot = free_ff;
      end else begin
         add_slot = '0;
      end
   end

   always_comb begin
      if (state_ff == ST_SCAN) begin
         rd_idx = idx_ff;
      end else if (mode_ff == MODE_GET || mode_ff == MODE_ERASE) begin
         rd_idx = match_ff;
      end else begin
         rd_idx = best_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      stamp_in      = stamp_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      best_vld_in   = best_vld_ff;
      best_in       = best_ff;
      best_key_in   = best_key_ff;
      best_stamp_in = best_stamp_ff;
      match_vld_in  = match_vld_ff;
      match_in      = match_ff;
      free_vld_in   = free_vld_ff;
      free_in       = free_ff;
      found_in      = found_ff;
      data_in       = data_ff;
      released_in   = released_ff;
      last_in       = last_ff;
      load          = 1'b0;
      scan_start    = 1'b0;
      wr            = '0;
      wr.key        = key_ff;
      wr.data       = value_ff;
      wr.stamp      = stamp_ff;
      wr.widx       = add_slot;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               mode_in    = req_ch.mode;
               key_in     = req_ch.key[TAG_BITS-1:0];
               value_in   = req_ch.value;
               scan_start = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (ent.valid) begin
               cnt_in = cnt_ff + CNT_W'(1);
               if (!best_vld_ff || cmp.better) begin
                  best_vld_in   = 1'b1;
                  best_in       = idx_ff;
                  best_key_in   = ent.key;
                  best_stamp_in = ent.stamp;
               end
               if (cmp.hit && !match_vld_ff) begin
                  match_vld_in = 1'b1;
                  match_in     = idx_ff;
               end
            end else if (!free_vld_ff) begin
               free_vld_in = 1'b1;
               free_in     = idx_ff;
            end
            idx_in = idx_ff + IDX_W'(1);
            if (idx_ff == LAST_IDX) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            unique case (mode_ff)
               MODE_ADD: begin
                  if (!evict || out_free) begin
                     wr.wen   = 1'b1;
                     wr.ken   = evict;
                     wr.kidx  = best_ff;
                     stamp_in = stamp_ff + STAMP_W'(1);
                     load     = evict;
                     // without an eviction a waiting word stays as it is
                     if (evict) begin
                        found_in    = 1'b0;
                        data_in     = ent.data;
                        released_in = 1'b1;
                        last_in     = 1'b1;
                     end
                     state_in = ST_IDLE;
                  end
               end
               MODE_GET, MODE_ERASE: begin
                  if (out_free) begin
                     load        = 1'b1;
                     found_in    = match_vld_ff;
                     data_in     = match_vld_ff ? ent.data : '0;
                     released_in = match_vld_ff && (mode_ff == MODE_ERASE);
                     last_in     = 1'b1;
                     wr.ken      = match_vld_ff && (mode_ff == MODE_ERASE);
                     wr.kidx     = match_ff;
                     state_in    = ST_IDLE;
                  end
               end
               MODE_CLEAR: begin
                  if (cnt_ff == '0) begin
                     state_in = ST_IDLE;
                  end else if (out_free) begin
                     load        = 1'b1;
                     found_in    = 1'b0;
                     data_in     = ent.data;
                     released_in = 1'b1;
                     last_in     = cnt_ff == CNT_W'(1);
                     wr.ken      = 1'b1;
                     wr.kidx     = best_ff;
                     if (cnt_ff == CNT_W'(1)) begin
                        state_in = ST_IDLE;
                     end else begin
                        scan_start = 1'b1;
                        state_in   = ST_SCAN;
                     end
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (scan_start) begin
         idx_in       = '0;
         cnt_in       = '0;
         best_vld_in  = 1'b0;
         match_vld_in = 1'b0;
         free_vld_in  = 1'b0;
      end
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      cap_in = csr_ch.valid ? csr_ch.capacity : cap_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_W'(CAP_RESET);
         stamp_ff     <= STAMP_W'(STAMP_RESET);
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         best_vld_ff  <= 1'b0;
         match_vld_ff <= 1'b0;
         free_vld_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         stamp_ff     <= stamp_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         best_vld_ff  <= best_vld_in;
         match_vld_ff <= match_vld_in;
         free_vld_ff  <= free_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      best_ff       <= best_in;
      best_key_ff   <= best_key_in;
      best_stamp_ff <= best_stamp_in;
      match_ff      <= match_in;
      free_ff       <= free_in;
      found_ff      <= found_in;
      data_ff       <= data_in;
      released_ff   <= released_in;
      last_ff       <= last_in;
   end

`ifndef SYNTH
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> state_ff == ST_SCAN)
      else $error("accepted word did not start a scan");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(ENTRIES))
      else $error("valid count above store size");

   a_evict_has_victim: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY && mode_ff == MODE_ADD && evict) |-> best_vld_ff)
      else $error("eviction without a victim");

   a_multi_only_clear: assert property (@(posedge clock) disable iff (reset)
      (load && !last_in) |-> mode_ff == MODE_CLEAR)
      else $error("non-final response outside clear");
`endif

endmodule
